// ----- sv/pdct_pkg.sv -----
// pdct_pkg: shared widths, command, reply and status codes, and the record types
// of the paired device challenge table
// no dependencies
`timescale 1ns / 1ps

package pdct_pkg;

   localparam int DEF_MAX_DEVICES = 16;

   localparam int CMD_W    = 3;
   localparam int WORD_W   = 32;
   localparam int ADDR_W   = 8;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;

   // configuration port
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam logic [CSR_AW-1:0] CSR_ADDR_PAIRING = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_ADDR_TIMEOUT = 3'd4;
   localparam logic [WORD_W-1:0] TIMEOUT_RESET    = 32'd30000;

   typedef enum logic [CMD_W-1:0] {
      CMD_PING   = 3'd0,
      CMD_DOOR   = 3'd1,
      CMD_PAIR   = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_CLEAR  = 3'd4,
      CMD_SWEEP  = 3'd5
   } cmd_type;

   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHAL    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CONFIRM = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_SUCCESS    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_PAIRED = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_INVALID    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_DISABLED   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd4;

   typedef struct packed {
      logic              pairing_enabled;
      logic [WORD_W-1:0] challenge_timeout;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [WORD_W-1:0] serial;
      logic [WORD_W-1:0] offered_challenge;
      logic [WORD_W-1:0] fresh_challenge;
      logic [WORD_W-1:0] now_ms;
      logic [ADDR_W-1:0] src_addr;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]   reply_kind;
      logic [STATUS_W-1:0] reply_status;
      logic [WORD_W-1:0]   reply_challenge;
      logic [ADDR_W-1:0]   reply_address;
      logic                door_event;
      logic                door_granted;
      logic                paired_event;
   } res_type;

   typedef struct packed {
      logic [WORD_W-1:0] serial;
      logic [WORD_W-1:0] challenge;
      logic [WORD_W-1:0] stamp;
   } entry_type;

endpackage

// ----- sv/pdct_req_if.sv -----
// pdct_req_if: request channel, valid/ready with the request fields
// depends on pdct_pkg
`timescale 1ns / 1ps

interface pdct_req_if;
   import pdct_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [WORD_W-1:0] serial;
   logic [WORD_W-1:0] offered_challenge;
   logic [WORD_W-1:0] fresh_challenge;
   logic [WORD_W-1:0] now_ms;
   logic [ADDR_W-1:0] src_addr;

   modport source (
      output valid, cmd, serial, offered_challenge, fresh_challenge, now_ms, src_addr,
      input  ready
   );
   modport sink (
      input  valid, cmd, serial, offered_challenge, fresh_challenge, now_ms, src_addr,
      output ready
   );
endinterface

// ----- sv/pdct_rsp_if.sv -----
// pdct_rsp_if: reply channel, valid/ready with the reply fields
// depends on pdct_pkg
`timescale 1ns / 1ps

interface pdct_rsp_if;
   import pdct_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   reply_kind;
   logic [STATUS_W-1:0] reply_status;
   logic [WORD_W-1:0]   reply_challenge;
   logic [ADDR_W-1:0]   reply_address;
   logic                door_event;
   logic                door_granted;
   logic                paired_event;

   modport source (
      output valid, reply_kind, reply_status, reply_challenge, reply_address,
             door_event, door_granted, paired_event,
      input  ready
   );
   modport sink (
      input  valid, reply_kind, reply_status, reply_challenge, reply_address,
             door_event, door_granted, paired_event,
      output ready
   );
endinterface

// ----- sv/pdct_csr.sv -----
// pdct_csr: apb-style register file holding pairing enable and challenge timeout
// depends on pdct_pkg
`timescale 1ns / 1ps

module pdct_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pdct_pkg::CSR_AW-1:0]    paddr,
   input  logic [pdct_pkg::CSR_DW-1:0]    pwdata,
   output logic [pdct_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready,
   output pdct_pkg::cfg_type              cfg
);
   import pdct_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr)
            CSR_ADDR_PAIRING: cfg_in.pairing_enabled   = pwdata[0];
            CSR_ADDR_TIMEOUT: cfg_in.challenge_timeout = pwdata[WORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pairing_enabled   <= 1'b0;
         cfg_ff.challenge_timeout <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr)
         CSR_ADDR_PAIRING: prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.pairing_enabled};
         CSR_ADDR_TIMEOUT: prdata = cfg_ff.challenge_timeout;
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/paired_device_challenge_table_unit.sv -----
// paired device challenge table: one request beat in, one reply beat out.
// each table entry is read through the single memory read port, then evaluated;
// a request walks the entries from entry 0, stopping at the matching serial (a
// sweep walks them all). a new request is taken only once the reply of the last
// one is loaded into the reply register. clear all, ignored codes and disabled
// pairing skip the walk.
// reset empties the table at once through the used/armed flip-flops.
`timescale 1ns / 1ps

module paired_device_challenge_table_unit #(
   parameter int MAX_DEVICES = pdct_pkg::DEF_MAX_DEVICES
) (
   input  logic                           clock,
   input  logic                           reset,
   pdct_req_if.sink                       req_bus,
   pdct_rsp_if.source                     rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pdct_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [pdct_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [pdct_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                           csr_pready
);
   import pdct_pkg::*;

   localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_DEVICES - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EVAL = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   cfg_type cfg;

   pdct_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   req_type                req_ff, req_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   res_type                res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   res_type                rsp_data_ff, rsp_data_in;
   logic [MAX_DEVICES-1:0] used_ff, used_in;
   logic [MAX_DEVICES-1:0] armed_ff, armed_in;

   // entry store: serial, challenge and stamp in one word
   entry_type              mem [MAX_DEVICES];
   entry_type              rd_data_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   entry_type              mem_wdata;

   logic                   hit;
   logic                   expired;
   logic [WORD_W-1:0]      age;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_ff];
   end

   assign hit     = used_ff[idx_ff] && (rd_data_ff.serial == req_ff.serial);
   assign age     = req_ff.now_ms - rd_data_ff.stamp;
   assign expired = age > cfg.challenge_timeout;

   always_comb begin
      logic stop;
      logic slot_free;
      logic [IDX_W-1:0] slot;

      stop          = 1'b0;
      slot_free     = free_found_ff || !used_ff[idx_ff];
      slot          = free_found_ff ? free_idx_ff : idx_ff;
      state_in      = state_ff;
      idx_in        = idx_ff;
      req_in        = req_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      res_in        = res_ff;
      used_in       = used_ff;
      armed_in      = armed_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = rd_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               req_in.cmd               = req_bus.cmd;
               req_in.serial            = req_bus.serial;
               req_in.offered_challenge = req_bus.offered_challenge;
               req_in.fresh_challenge   = req_bus.fresh_challenge;
               req_in.now_ms            = req_bus.now_ms;
               req_in.src_addr          = req_bus.src_addr;
               idx_in                   = '0;
               free_found_in            = 1'b0;
               res_in                   = '0;
               case (req_bus.cmd)
                  CMD_CLEAR: begin
                     used_in  = '0;
                     armed_in = '0;
                     state_in = ST_DONE;
                  end
                  CMD_PAIR: begin
                     if (!cfg.pairing_enabled) begin
                        res_in.reply_kind   = KIND_CONFIRM;
                        res_in.reply_status = STAT_DISABLED;
                        state_in            = ST_DONE;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  CMD_PING, CMD_DOOR, CMD_REMOVE, CMD_SWEEP: state_in = ST_READ;
                  default: state_in = ST_DONE;
               endcase
            end
         end

         ST_READ: state_in = ST_EVAL;

         ST_EVAL: begin
            if (!used_ff[idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            case (req_ff.cmd)
               CMD_PING: begin
                  if (hit) begin
                     stop                   = 1'b1;
                     mem_we                 = 1'b1;
                     mem_wdata.challenge    = req_ff.fresh_challenge;
                     mem_wdata.stamp        = req_ff.now_ms;
                     armed_in[idx_ff]       = 1'b1;
                     res_in.reply_kind      = KIND_CHAL;
                     res_in.reply_challenge = req_ff.fresh_challenge;
                  end
               end
               CMD_DOOR: begin
                  if (hit) begin
                     stop              = 1'b1;
                     res_in.reply_kind = KIND_ACK;
                     res_in.door_event = 1'b1;
                     if (!armed_ff[idx_ff]) begin
                        res_in.reply_status = STAT_INVALID;
                     end else if (expired) begin
                        armed_in[idx_ff]    = 1'b0;
                        res_in.reply_status = STAT_INVALID;
                     end else if (rd_data_ff.challenge == req_ff.offered_challenge) begin
                        armed_in[idx_ff]    = 1'b0;
                        mem_we              = 1'b1;
                        mem_wdata.challenge = '0;
                        res_in.door_granted = 1'b1;
                     end else begin
                        res_in.reply_status = STAT_INVALID;
                     end
                  end
               end
               CMD_PAIR: begin
                  if (hit) begin
                     stop                = 1'b1;
                     res_in.reply_kind   = KIND_CONFIRM;
                     res_in.reply_status = STAT_SUCCESS;
                  end
               end
               CMD_REMOVE: begin
                  if (hit) begin
                     stop             = 1'b1;
                     used_in[idx_ff]  = 1'b0;
                     armed_in[idx_ff] = 1'b0;
                  end
               end
               CMD_SWEEP: begin
                  if (used_ff[idx_ff] && armed_ff[idx_ff] && expired) begin
                     armed_in[idx_ff]    = 1'b0;
                     mem_we              = 1'b1;
                     mem_wdata.challenge = '0;
                  end
               end
               default: ;
            endcase

            if (stop) begin
               state_in = ST_DONE;
            end else if (idx_ff == LAST_IDX) begin
               // whole table walked without a serial match
               state_in = ST_DONE;
               case (req_ff.cmd)
                  CMD_PING: begin
                     res_in.reply_kind   = KIND_ACK;
                     res_in.reply_status = STAT_NOT_PAIRED;
                  end
                  CMD_DOOR: begin
                     res_in.reply_kind   = KIND_ACK;
                     res_in.reply_status = STAT_NOT_PAIRED;
                     res_in.door_event   = 1'b1;
                  end
                  CMD_PAIR: begin
                     res_in.reply_kind = KIND_CONFIRM;
                     if (slot_free) begin
                        mem_we              = 1'b1;
                        mem_waddr           = slot;
                        mem_wdata.serial    = req_ff.serial;
                        mem_wdata.challenge = '0;
                        mem_wdata.stamp     = '0;
                        used_in[slot]       = 1'b1;
                        armed_in[slot]      = 1'b0;
                        res_in.paired_event = 1'b1;
                     end else begin
                        res_in.reply_status = STAT_FULL;
                     end
                  end
                  default: ;
               endcase
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in               = res_ff;
               rsp_data_in.reply_address = (res_ff.reply_kind != KIND_NONE) ?
                                           req_ff.src_addr : '0;
               state_in                  = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         armed_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         armed_ff     <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.reply_kind      = rsp_data_ff.reply_kind;
   assign rsp_bus.reply_status    = rsp_data_ff.reply_status;
   assign rsp_bus.reply_challenge = rsp_data_ff.reply_challenge;
   assign rsp_bus.reply_address   = rsp_data_ff.reply_address;
   assign rsp_bus.door_event      = rsp_data_ff.door_event;
   assign rsp_bus.door_granted    = rsp_data_ff.door_granted;
   assign rsp_bus.paired_event    = rsp_data_ff.paired_event;

endmodule
